// ----- rtl/smp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and helpers of the servo motion profiler.
package smp_pkg;

  localparam int CHANNELS_DEF = 16;

  localparam logic [11:0] LOWER_RST     = 12'd544;
  localparam logic [11:0] UPPER_RST     = 12'd2400;
  localparam logic [11:0] MIN_ANGLE_RST = 12'd0;
  localparam logic [11:0] MAX_ANGLE_RST = 12'd1800;

  // Divider step counts: fraction of a move, and the linear angle/width map.
  localparam logic [5:0] DIV_STEPS_FRAC = 6'd16;
  localparam logic [5:0] DIV_STEPS_MAP  = 6'd25;

  typedef enum logic [2:0] {
    MODE_TICK        = 3'd0,
    MODE_WR_WIDTH    = 3'd1,
    MODE_SWEEP_WIDTH = 3'd2,
    MODE_WAIT        = 3'd3,
    MODE_WR_ANGLE    = 3'd4,
    MODE_SWEEP_ANGLE = 3'd5,
    MODE_READ        = 3'd6,
    MODE_BOUNDS      = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    REG_EASE      = 2'd0,
    REG_MIN_ANGLE = 2'd1,
    REG_MAX_ANGLE = 2'd2
  } reg_index_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_DEC,
    S_ADIV,
    S_AMUL1,
    S_AMUL2,
    S_AFIN,
    S_MMUL1,
    S_MMUL2,
    S_MDSTART,
    S_MDIV,
    S_APPLY,
    S_WRITE,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [11:0] cur;
    logic [11:0] tgt;
    logic [11:0] st;
    logic [15:0] dur;
    logic [31:0] mst;
    logic        first;
    logic [11:0] lo;
    logic [11:0] hi;
  } entry_t;

  localparam entry_t ENTRY_RST = '{
    cur: 12'd0, tgt: 12'd0, st: 12'd0, dur: 16'd0, mst: 32'd0,
    first: 1'b1, lo: LOWER_RST, hi: UPPER_RST
  };

  typedef struct packed {
    logic        start;
    logic [15:0] rem_init;
    logic [31:0] dividend;
    logic [15:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  function automatic logic [11:0] sat_q(input logic [31:0] v);
    sat_q = (|v[31:12]) ? 12'hFFF : v[11:0];
  endfunction

endpackage

// ----- rtl/smp_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle.
module smp_div (
  input  logic               clk,
  input  logic               rst,
  input  smp_pkg::div_req_t  req,
  output smp_pkg::div_rsp_t  rsp
);
  import smp_pkg::*;

  logic [15:0] rem;
  logic [15:0] dvs;
  logic [31:0] dvd;
  logic [31:0] quo;
  logic [5:0]  cnt;
  logic        run;
  logic        done;
  logic [16:0] trial;
  logic        fits;

  assign trial = {rem, dvd[31]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.steps;
      end else if (run) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      dvs <= req.divisor;
      quo <= '0;
    end else if (run) begin
      rem <= fits ? 16'(trial - {1'b0, dvs}) : trial[15:0];
      dvd <= {dvd[30:0], 1'b0};
      quo <= {quo[30:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quo;

  a_done_after_run: assert property (@(posedge clk) disable iff (rst) done |-> $past(run))
    else $error("divider done without a run");
  a_rem_below: assert property (@(posedge clk) disable iff (rst) run |-> rem < dvs)
    else $error("partial remainder reached the divisor");
  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !run)
    else $error("divider restarted while running");

endmodule

// ----- rtl/servo_motion_profiler.sv -----
`timescale 1ns / 1ps
// Top level of the servo motion profiler.
//
// Commands enter on start while busy is low; mode selects tick, width or
// angle moves, wait, read or bound loading. A tick walks every channel in
// order and gives one result per channel, the final one with last set; a
// read gives one result with last set. Other commands give no result.
// Each result is shown for one cycle with strobe high, the cycle after its
// channel finishes; the receiver must take it then, there is no back pressure.
// Channel state lives in one memory, one word per channel, read back in the
// cycle after the address and written back when the channel is done.
// A channel may pass through the 16-step fraction divider and the 25-step
// map divider. A tick runs the channels one after another, and one item
// ends before the next starts.
// Configuration is taken on cfg_valid while the block is idle and no command
// is offered (cfg_ready).
// Reset returns the registers and every channel to their initial values at
// once through per-channel valid bits; no sweep is needed.
module servo_motion_profiler #(
  parameter int CHANNELS = smp_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [7:0]  channel,
  input  logic [11:0] value,
  input  logic [15:0] duration_ms,
  input  logic        calibration,
  input  logic [31:0] now_ms,
  input  logic [11:0] max_bound,
  output logic        strobe,
  output logic [7:0]  out_channel,
  output logic [11:0] width_us,
  output logic [11:0] angle,
  output logic        moving,
  output logic        channel_valid,
  output logic [11:0] min_width,
  output logic [11:0] max_width,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import smp_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state, state_next;

  mode_t       mode_q;
  logic [7:0]  chan_q;
  logic [11:0] val_q;
  logic [15:0] dur_q;
  logic        cal_q;
  logic [31:0] now_q;
  logic [11:0] bmax_q;
  logic        chan_ok;
  logic [CW-1:0] idx;

  logic        ease;
  logic [11:0] min_angle;
  logic [11:0] max_angle;

  entry_t mem [CHANNELS];
  entry_t rdata;
  entry_t mem_entry;
  entry_t e;
  logic [CHANNELS-1:0] vld;
  logic        rvld;
  logic        rd_en;
  logic [CW-1:0] rd_addr;
  logic        wr_en;

  logic [15:0] f;
  logic signed [47:0] prod;
  logic signed [26:0] acc;
  logic [11:0] map_res;
  logic        map_a2w;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        in_range;
  logic        last_ch;
  logic [31:0] elapsed;
  logic        need_div;
  logic [11:0] wclamp;
  state_t      map_done_state;

  // map operands
  logic [11:0] a_cl;
  logic [11:0] m_base;
  logic signed [12:0] m_den, m_x, m_y, m_den_neg;
  logic [11:0] m_den_abs;
  logic signed [25:0] xy;
  logic [23:0] bd;
  logic signed [26:0] acc_v;

  // advance operands
  logic signed [12:0] d;
  logic [16:0] h;
  logic [33:0] hh;
  logic signed [29:0] df;
  logic signed [44:0] dh;
  logic signed [47:0] num;
  logic [11:0] adv_cur;

  smp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign in_range  = {1'b0, channel} < 9'(CHANNELS);
  assign last_ch   = idx == CW'(CHANNELS - 1);
  assign busy      = state != S_IDLE;
  assign cfg_ready = (state == S_IDLE) && !start;
  assign mem_entry = rvld ? rdata : ENTRY_RST;

  assign elapsed  = now_q - e.mst;
  assign need_div = !e.first && (e.dur != 16'd0) && (elapsed < {16'd0, e.dur});
  assign map_done_state = map_a2w ? S_APPLY : S_EMIT;

  always_comb begin
    if (val_q < e.lo) begin
      wclamp = e.lo;
    end else if (val_q > e.hi) begin
      wclamp = e.hi;
    end else begin
      wclamp = val_q;
    end
  end

  // Linear map: base + x*y/den, truncated, saturated.
  always_comb begin
    if (val_q < min_angle) begin
      a_cl = min_angle;
    end else if (val_q > max_angle) begin
      a_cl = max_angle;
    end else begin
      a_cl = val_q;
    end
    if (map_a2w) begin
      m_base = e.lo;
      m_den  = $signed({1'b0, max_angle}) - $signed({1'b0, min_angle});
      m_x    = $signed({1'b0, a_cl}) - $signed({1'b0, min_angle});
      m_y    = $signed({1'b0, e.hi}) - $signed({1'b0, e.lo});
    end else begin
      m_base = min_angle;
      m_den  = $signed({1'b0, e.hi}) - $signed({1'b0, e.lo});
      m_x    = $signed({1'b0, e.cur}) - $signed({1'b0, e.lo});
      m_y    = $signed({1'b0, max_angle}) - $signed({1'b0, min_angle});
    end
    m_den_neg = -m_den;
    m_den_abs = m_den[12] ? m_den_neg[11:0] : m_den[11:0];
  end

  assign xy    = m_x * m_y;
  assign bd    = m_base * m_den_abs;
  assign acc_v = $signed({3'b000, bd})
               + (m_den[12] ? -27'($signed(prod[25:0])) : 27'($signed(prod[25:0])));

  // Profile arithmetic.
  assign d  = $signed({1'b0, e.tgt}) - $signed({1'b0, e.st});
  assign h  = (f <= 16'd32768) ? {1'b0, f} : 17'd65536 - {1'b0, f};
  assign hh = h * h;
  assign df = d * $signed({1'b0, f});
  assign dh = d * $signed({1'b0, prod[30:0]});

  always_comb begin
    if (!ease) begin
      num     = $signed({20'd0, e.st, 16'd0}) + prod;
      adv_cur = num[47] ? 12'd0 : sat_q(num[47:16]);
    end else if (f <= 16'd32768) begin
      num     = $signed({4'd0, e.st, 32'd0}) + (prod <<< 1);
      adv_cur = num[47] ? 12'd0 : sat_q({16'd0, num[47:32]});
    end else begin
      num     = $signed({4'd0, e.tgt, 32'd0}) - (prod <<< 1);
      adv_cur = num[47] ? 12'd0 : sat_q({16'd0, num[47:32]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = idx;
    wr_en      = 1'b0;
    div_req    = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (mode == MODE_TICK) begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = S_LOAD;
          end else if (!in_range) begin
            if (mode == MODE_READ) state_next = S_EMIT;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = channel[CW-1:0];
            state_next = S_LOAD;
          end
        end
      end
      S_LOAD: state_next = S_DEC;
      S_DEC: begin
        case (mode_q)
          MODE_TICK: begin
            if (need_div) begin
              div_req.start    = 1'b1;
              div_req.rem_init = elapsed[15:0];
              div_req.divisor  = e.dur;
              div_req.steps    = DIV_STEPS_FRAC;
              state_next       = S_ADIV;
            end else begin
              state_next = S_MMUL1;
            end
          end
          MODE_READ, MODE_WR_ANGLE, MODE_SWEEP_ANGLE: state_next = S_MMUL1;
          default: state_next = S_WRITE;
        endcase
      end
      S_ADIV: if (div_rsp.done) state_next = S_AMUL1;
      S_AMUL1: state_next = ease ? S_AMUL2 : S_AFIN;
      S_AMUL2: state_next = S_AFIN;
      S_AFIN: state_next = S_MMUL1;
      S_MMUL1: state_next = (m_den == 13'sd0) ? map_done_state : S_MMUL2;
      S_MMUL2: state_next = S_MDSTART;
      S_MDSTART: begin
        if (acc[26]) begin
          state_next = map_done_state;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {acc[24:0], 7'd0};
          div_req.divisor  = {4'd0, m_den_abs};
          div_req.steps    = DIV_STEPS_MAP;
          state_next       = S_MDIV;
        end
      end
      S_MDIV: if (div_rsp.done) state_next = map_done_state;
      S_APPLY: state_next = S_WRITE;
      S_WRITE: begin
        wr_en      = 1'b1;
        state_next = S_IDLE;
      end
      S_EMIT: begin
        wr_en = chan_ok;
        if (mode_q == MODE_TICK && !last_ch) begin
          rd_en      = 1'b1;
          rd_addr    = idx + CW'(1);
          state_next = S_LOAD;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Channel memory with per-entry valid bits standing in for the reset values.
  always_ff @(posedge clk) begin
    if (wr_en) mem[idx] <= e;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rvld <= 1'b0;
    end else begin
      if (wr_en) vld[idx] <= 1'b1;
      if (rd_en) rvld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ease      <= 1'b1;
      min_angle <= MIN_ANGLE_RST;
      max_angle <= MAX_ANGLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EASE:      ease      <= cfg_data[0];
        REG_MIN_ANGLE: min_angle <= cfg_data;
        REG_MAX_ANGLE: max_angle <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          mode_q  <= mode_t'(mode);
          chan_q  <= channel;
          val_q   <= value;
          dur_q   <= duration_ms;
          cal_q   <= calibration;
          now_q   <= now_ms;
          bmax_q  <= max_bound;
          idx     <= (mode == MODE_TICK) ? '0 : channel[CW-1:0];
          chan_ok <= (mode == MODE_TICK) || in_range;
        end
      end
      S_LOAD: e <= mem_entry;
      S_DEC: begin
        map_a2w <= (mode_q == MODE_WR_ANGLE) || (mode_q == MODE_SWEEP_ANGLE);
        case (mode_q)
          MODE_TICK: begin
            if (e.first) begin
              e.mst   <= now_q;
              e.cur   <= (e.dur == 16'd0) ? e.tgt : e.st;
              e.first <= 1'b0;
            end else if (e.dur == 16'd0) begin
              e.cur <= e.tgt;
            end else if (!need_div) begin
              e.dur <= '0;
              e.cur <= e.tgt;
            end
          end
          MODE_WR_WIDTH, MODE_SWEEP_WIDTH: begin
            e.st    <= e.cur;
            e.tgt   <= cal_q ? val_q : wclamp;
            e.dur   <= (mode_q == MODE_SWEEP_WIDTH) ? dur_q : 16'd0;
            e.first <= 1'b1;
          end
          MODE_WAIT: begin
            e.st    <= e.cur;
            e.tgt   <= e.cur;
            e.dur   <= dur_q;
            e.first <= 1'b1;
          end
          MODE_BOUNDS: begin
            e.lo <= val_q;
            e.hi <= bmax_q;
          end
          default: ;
        endcase
      end
      S_ADIV: if (div_rsp.done) f <= div_rsp.quot[15:0];
      S_AMUL1: prod <= ease ? $signed({14'd0, hh}) : 48'(df);
      S_AMUL2: prod <= 48'(dh);
      S_AFIN: e.cur <= adv_cur;
      S_MMUL1: begin
        if (m_den == 13'sd0) begin
          map_res <= m_base;
        end else begin
          prod <= 48'(xy);
        end
      end
      S_MMUL2: acc <= acc_v;
      S_MDSTART: if (acc[26]) map_res <= '0;
      S_MDIV: if (div_rsp.done) map_res <= sat_q(div_rsp.quot);
      S_APPLY: begin
        e.st    <= e.cur;
        e.tgt   <= map_res;
        e.dur   <= (mode_q == MODE_SWEEP_ANGLE) ? dur_q : 16'd0;
        e.first <= 1'b1;
      end
      S_EMIT: if (mode_q == MODE_TICK && !last_ch) idx <= idx + CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= state == S_EMIT;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT) begin
      out_channel <= (mode_q == MODE_TICK) ? 8'(idx) : chan_q;
      if (chan_ok) begin
        width_us      <= e.cur;
        angle         <= map_res;
        moving        <= e.cur != e.tgt;
        channel_valid <= 1'b1;
        min_width     <= e.lo;
        max_width     <= e.hi;
        last          <= (mode_q == MODE_TICK) ? last_ch : 1'b1;
      end else begin
        width_us      <= '0;
        angle         <= '0;
        moving        <= 1'b0;
        channel_valid <= 1'b0;
        min_width     <= '0;
        max_width     <= '0;
        last          <= 1'b1;
      end
    end
  end

  a_strobe_src: assert property (@(posedge clk) disable iff (rst)
      strobe |-> $past(state) == S_EMIT)
    else $error("result strobe without an emit");
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
      strobe && !last |=> busy)
    else $error("tick run stopped before its last channel");
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
      div_rsp.done |-> (state == S_ADIV || state == S_MDIV))
    else $error("divider finished while nobody waits");
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
      start && !busy && mode == MODE_TICK |=> busy)
    else $error("tick transfer did not start a run");

endmodule
